// ----- rtl/lcdnib_pkg.sv -----
// shared types, codes and tables of the character lcd nibble sequencer
package lcdnib_pkg;

    // default for the largest number of decimal digits shown
    localparam int MAX_DIGITS_DEF = 5;

    // depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // reset value of the enable hold time register
    localparam logic [7:0] HOLD_TICKS_RESET = 8'd4;

    // request kinds as they arrive on the input
    localparam logic [2:0] KIND_CMD    = 3'd0;
    localparam logic [2:0] KIND_DATA   = 3'd1;
    localparam logic [2:0] KIND_CURSOR = 3'd2;
    localparam logic [2:0] KIND_NUMBER = 3'd3;
    localparam logic [2:0] KIND_INIT   = 3'd4;

    // register indexes of the configuration port
    localparam logic [0:0] REG_HOLD_TICKS = 1'b0;

    // line base addresses and the ascii digit base
    localparam logic [7:0] LINE1_BASE = 8'h80;
    localparam logic [7:0] LINE2_BASE = 8'hC0;
    localparam logic [7:0] ASCII_ZERO = 8'h30;

    // register select levels
    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    // reciprocal of ten for 16-bit values, used with a 19-bit shift
    localparam logic [15:0] RECIP_TEN = 16'hCCCD;
    localparam int          RECIP_SHIFT = 19;

    // number of bytes in the initialisation sequence
    localparam logic [3:0] INIT_BYTES = 4'd5;

    // job kinds carried from front to back
    typedef enum logic [2:0] {
        OP_CMD    = 3'd0,
        OP_DATA   = 3'd1,
        OP_CURSOR = 3'd2,
        OP_NUMBER = 3'd3,
        OP_INIT   = 3'd4
    } op_t;

    // control part of one job word
    typedef struct packed {
        op_t        op;
        logic [7:0] byte_val;
        logic       cursor_en;
        logic [2:0] count;
    } job_t;

    // initialisation command sequence
    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h02;
            3'd1:    b = 8'h28;
            3'd2:    b = 8'h0C;
            3'd3:    b = 8'h01;
            3'd4:    b = 8'h80;
            default: b = 8'h80;
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/lcdnib_front.sv -----
// front end: accepts requests, classifies them and extracts decimal digits
module lcdnib_front #(
    parameter int MAX_DIGITS = lcdnib_pkg::MAX_DIGITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [2:0]            kind,
    input  logic [7:0]            byte_value,
    input  logic [7:0]            row,
    input  logic [7:0]            column,
    input  logic [15:0]           number,
    input  logic [2:0]            digit_count,
    output logic                  q_push,
    input  logic                  q_full,
    output lcdnib_pkg::job_t      q_job,
    output logic [(((MAX_DIGITS < 7) ? MAX_DIGITS : 7) * 4)-1:0] q_digits
);

    // a three-bit count never asks for more than seven digits
    localparam int DIG_N = (MAX_DIGITS < 7) ? MAX_DIGITS : 7;

    typedef enum logic [1:0] {
        F_IDLE  = 2'b01,
        F_DIGIT = 2'b10
    } fstate_t;

    fstate_t           state_reg, state_next;
    logic [15:0]       val_reg;
    logic [2:0]        done_reg, done_next;
    lcdnib_pkg::job_t  job_reg;
    logic [3:0]        digits_reg [DIG_N];

    logic              accept;
    logic              row_ok;
    logic [7:0]        cursor_byte;
    logic [2:0]        cnt_sat;
    lcdnib_pkg::job_t  new_job;
    logic              new_direct;
    logic              new_digits;
    logic [31:0]       prod;
    logic [12:0]       quot;
    logic [15:0]       quot_ten;
    logic [15:0]       rem_full;
    logic              digit_step;

    // classify the request on the input
    always_comb
    begin
        row_ok      = (row == 8'd1) || (row == 8'd2);
        cursor_byte = (row == 8'd1) ? (lcdnib_pkg::LINE1_BASE + column)
                                    : (lcdnib_pkg::LINE2_BASE + column);
        if (int'(digit_count) > MAX_DIGITS)
            cnt_sat = 3'(MAX_DIGITS);
        else
            cnt_sat = digit_count;
        new_job.op        = lcdnib_pkg::OP_CMD;
        new_job.byte_val  = byte_value;
        new_job.cursor_en = 1'b0;
        new_job.count     = 3'd0;
        new_direct        = 1'b0;
        new_digits        = 1'b0;
        case (kind)
            lcdnib_pkg::KIND_CMD:
            begin
                new_direct = 1'b1;
            end
            lcdnib_pkg::KIND_DATA:
            begin
                new_job.op = lcdnib_pkg::OP_DATA;
                new_direct = 1'b1;
            end
            lcdnib_pkg::KIND_CURSOR:
            begin
                new_job.op       = lcdnib_pkg::OP_CURSOR;
                new_job.byte_val = cursor_byte;
                new_direct       = row_ok;
            end
            lcdnib_pkg::KIND_NUMBER:
            begin
                new_job.op        = lcdnib_pkg::OP_NUMBER;
                new_job.byte_val  = cursor_byte;
                new_job.cursor_en = row_ok;
                new_job.count     = cnt_sat;
                new_direct        = row_ok && (cnt_sat == 3'd0);
                new_digits        = (cnt_sat != 3'd0);
            end
            lcdnib_pkg::KIND_INIT:
            begin
                new_job.op = lcdnib_pkg::OP_INIT;
                new_direct = 1'b1;
            end
            default:
            begin
                new_direct = 1'b0;
            end
        endcase
    end

    assign full   = (state_reg != F_IDLE) || q_full;
    assign accept = push && !full;

    // one decimal digit per cycle by reciprocal multiply
    assign prod       = val_reg * lcdnib_pkg::RECIP_TEN;
    assign quot       = prod[31:lcdnib_pkg::RECIP_SHIFT];
    assign quot_ten   = {quot, 3'b000} + {2'b00, quot, 1'b0};
    assign rem_full   = val_reg - quot_ten;
    assign digit_step = (state_reg == F_DIGIT) && (done_reg != job_reg.count);

    // sequencing of the front
    always_comb
    begin
        state_next = state_reg;
        done_next  = done_reg;
        q_push     = 1'b0;
        q_job      = new_job;
        case (state_reg)
            F_IDLE:
            begin
                q_push = accept && new_direct;
                if (accept && new_digits)
                begin
                    state_next = F_DIGIT;
                    done_next  = 3'd0;
                end
            end
            F_DIGIT:
            begin
                q_job = job_reg;
                if (digit_step)
                    done_next = done_reg + 3'd1;
                else if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            done_reg  <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // request capture and digit store
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg <= new_job;
            val_reg <= number;
        end
        else if (digit_step)
        begin
            val_reg <= {3'b000, quot};
        end
        for (int i = 0; i < DIG_N; i++)
        begin
            if (digit_step && (done_reg == 3'(i)))
                digits_reg[i] <= rem_full[3:0];
        end
    end

    // flatten digits for the queue, least significant in entry zero
    always_comb
    begin
        for (int i = 0; i < DIG_N; i++)
            q_digits[i*4 +: 4] = digits_reg[i];
    end

endmodule

// ----- rtl/lcdnib_queue.sv -----
// short job queue between front and back, first word shown ahead
module lcdnib_queue #(
    parameter int WIDTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             q_full,
    input  logic             rd_en,
    output logic             q_valid,
    output logic [WIDTH-1:0] rd_data
);

    localparam int DEPTH = lcdnib_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr, do_rd;

    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && q_valid;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ----- rtl/lcdnib_back.sv -----
// back end: walks a job nibble by nibble into the output register
module lcdnib_back #(
    parameter int MAX_DIGITS = lcdnib_pkg::MAX_DIGITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  lcdnib_pkg::job_t      q_job,
    input  logic [(((MAX_DIGITS < 7) ? MAX_DIGITS : 7) * 4)-1:0] q_digits,
    output logic                  q_pop,
    input  logic                  pop,
    output logic                  empty,
    output logic                  register_select,
    output logic [3:0]            nibble,
    output logic                  last
);

    localparam int DIG_N = (MAX_DIGITS < 7) ? MAX_DIGITS : 7;

    logic [3:0] nib_idx_reg;
    logic       out_valid_reg;
    logic       rs_reg;
    logic [3:0] nib_reg;
    logic       last_reg;

    logic       advance;
    logic [2:0] byte_idx;
    logic [3:0] total;
    logic [4:0] last_idx;
    logic       is_last;
    logic [2:0] dig_idx;
    logic [3:0] dig_sel;
    logic [7:0] cur_byte;
    logic       cur_rs;

    assign byte_idx = nib_idx_reg[3:1];
    assign advance  = q_valid && (!out_valid_reg || pop);

    // byte count of the job and position of its final nibble
    always_comb
    begin
        case (q_job.op)
            lcdnib_pkg::OP_INIT:   total = lcdnib_pkg::INIT_BYTES;
            lcdnib_pkg::OP_NUMBER: total = {3'b000, q_job.cursor_en} + {1'b0, q_job.count};
            default:               total = 4'd1;
        endcase
        last_idx = {total, 1'b0} - 5'd1;
        is_last  = (nib_idx_reg == last_idx[3:0]);
    end

    // digit for this byte, most significant first
    always_comb
    begin
        dig_idx = q_job.count - 3'd1 - (byte_idx - {2'b00, q_job.cursor_en});
        dig_sel = 4'd0;
        for (int i = 0; i < DIG_N; i++)
        begin
            if (dig_idx == 3'(i))
                dig_sel = q_digits[i*4 +: 4];
        end
    end

    // byte and register select of the current position
    always_comb
    begin
        cur_byte = q_job.byte_val;
        cur_rs   = lcdnib_pkg::RS_CMD;
        case (q_job.op)
            lcdnib_pkg::OP_DATA:
            begin
                cur_rs = lcdnib_pkg::RS_DATA;
            end
            lcdnib_pkg::OP_INIT:
            begin
                cur_byte = lcdnib_pkg::init_byte(byte_idx);
            end
            lcdnib_pkg::OP_NUMBER:
            begin
                if (!(q_job.cursor_en && (byte_idx == 3'd0)))
                begin
                    cur_byte = lcdnib_pkg::ASCII_ZERO | {4'h0, dig_sel};
                    cur_rs   = lcdnib_pkg::RS_DATA;
                end
            end
            default:
            begin
                cur_rs = lcdnib_pkg::RS_CMD;
            end
        endcase
    end

    assign q_pop = advance && is_last;

    // position counter and output word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nib_idx_reg   <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                nib_idx_reg   <= is_last ? 4'd0 : nib_idx_reg + 4'd1;
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output word, high nibble first
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rs_reg   <= cur_rs;
            nib_reg  <= nib_idx_reg[0] ? cur_byte[3:0] : cur_byte[7:4];
            last_reg <= is_last;
        end
    end

    assign empty           = !out_valid_reg;
    assign register_select = rs_reg;
    assign nibble          = nib_reg;
    assign last            = last_reg;

endmodule

// ----- rtl/char_lcd_nibble_sequencer.sv -----
// top level of the character lcd nibble sequencer
//
// Requests come in on a queue-style port: a word is taken when push is high
// and full is low. Each request turns into the 4-bit transfers of a
// character display, one output word per nibble, high nibble first, with
// last set on the final nibble of the request. Results leave on a queue-style
// port: the oldest word is shown while empty is low and is taken with pop.
// Flow: a request passes the front end, the job queue and the output register;
// a show-number request first waits in the iterative divide-by-ten unit of
// the front end for its digits, which also holds full for that time.
// Throughput: one nibble per cycle at the output while pop stays high; a request
// sends two nibbles per byte, and a two-word job queue lets the front take new
// requests while the back still sends nibbles.
// When pop stays low the output word holds, the queue fills and full rises.
// Reset clears all control state; the enable hold time returns to 4 ticks.
// The hold time register sits at address 0 of the APB port and is readable.
module char_lcd_nibble_sequencer #(
    parameter int MAX_DIGITS = lcdnib_pkg::MAX_DIGITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  kind,
    input  logic [7:0]  byte_value,
    input  logic [7:0]  row,
    input  logic [7:0]  column,
    input  logic [15:0] number,
    input  logic [2:0]  digit_count,
    output logic        empty,
    input  logic        pop,
    output logic        register_select,
    output logic [3:0]  nibble,
    output logic        last
);

    localparam int DIG_N = (MAX_DIGITS < 7) ? MAX_DIGITS : 7;
    localparam int JOB_W = $bits(lcdnib_pkg::job_t) + DIG_N * 4;

    logic [7:0]       hold_ticks_reg;
    logic             cfg_write;

    logic             f_push;
    logic             q_full;
    lcdnib_pkg::job_t f_job;
    logic [DIG_N*4-1:0] f_digits;
    logic             q_valid;
    logic             q_pop;
    logic [JOB_W-1:0] q_head;
    lcdnib_pkg::job_t b_job;
    logic [DIG_N*4-1:0] b_digits;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_ticks_reg <= lcdnib_pkg::HOLD_TICKS_RESET;
        else if (cfg_write && (paddr[2] == lcdnib_pkg::REG_HOLD_TICKS))
            hold_ticks_reg <= pwdata[7:0];
    end

    assign prdata = (paddr[2] == lcdnib_pkg::REG_HOLD_TICKS) ? {24'h0, hold_ticks_reg}
                                                             : 32'h0;

    // front end
    lcdnib_front #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .byte_value  (byte_value),
        .row         (row),
        .column      (column),
        .number      (number),
        .digit_count (digit_count),
        .q_push      (f_push),
        .q_full      (q_full),
        .q_job       (f_job),
        .q_digits    (f_digits)
    );

    // job queue
    lcdnib_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (f_push),
        .wr_data ({f_job, f_digits}),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .q_valid (q_valid),
        .rd_data (q_head)
    );

    assign b_job    = q_head[JOB_W-1 -: $bits(lcdnib_pkg::job_t)];
    assign b_digits = q_head[DIG_N*4-1:0];

    // back end
    lcdnib_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_job           (b_job),
        .q_digits        (b_digits),
        .q_pop           (q_pop),
        .pop             (pop),
        .empty           (empty),
        .register_select (register_select),
        .nibble          (nibble),
        .last            (last)
    );

    // a request never breaks off in the middle
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last) |=> !empty)
        else $error("output ran dry inside a request");

    // a waiting job reaches a free output register at once
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && empty) |=> !empty)
        else $error("queued job not moved to the output");

    // the queue is only drained on the final nibble of a job
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (!empty && last))
        else $error("job left the queue before its final nibble");

    // hold time register takes the written value
    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && (paddr[2] == lcdnib_pkg::REG_HOLD_TICKS))
            |=> (hold_ticks_reg == $past(pwdata[7:0])))
        else $error("hold time write lost");

endmodule
